FILE: sv/iobs_pkg.sv
`timescale 1ns / 1ps
// Package for the I/O board status frame builder: item types, frame constants
// and the small functions shared by the formatter and the serialiser.
// Depends on nothing.
package iobs_pkg;

	// Frame layout: two sync bytes, ten data bytes, two CRC bytes.
	localparam int FRAME_LEN = 14;
	localparam int DATA_LEN = 10;
	localparam int IDX_W = $clog2(FRAME_LEN);
	localparam int DIDX_W = $clog2(DATA_LEN);

	// Byte positions within the frame.
	localparam logic [IDX_W-1:0] IDX_DATA_FIRST = IDX_W'(2);
	localparam logic [IDX_W-1:0] IDX_DATA_LAST = IDX_W'(11);
	localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(12);
	localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(13);

	localparam logic [7:0] SYNC_BYTE = 8'hAA;
	localparam logic [7:0] STATUS_BASE = 8'h40;
	localparam logic [7:0] STATUS_COIN = 8'h80;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Position of the coin bit in the raw control word.
	localparam int COIN_BIT = 2;

	typedef struct packed {
		logic [15:0] control_word;
		logic [7:0] steer_reading;
		logic [7:0] throttle_reading;
		logic [7:0] brake_reading;
	} poll_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic frame_end;
	} frame_item_t;

	// Ten data bytes of one frame, element 0 sent first.
	typedef logic [DATA_LEN-1:0][7:0] frame_data_t;

	// Analog word: (255 - reading) * 4, which is the inverted reading shifted by two.
	function automatic logic [15:0] scale_analog(input logic [7:0] raw);
		return {6'b0, ~raw, 2'b00};
	endfunction

	// Button word built from selected control bits; the top six bits stay clear.
	function automatic logic [15:0] remap_buttons(input logic [15:0] cw);
		return {6'b0, cw[0], cw[1], cw[9], cw[10], cw[3], cw[8],
			cw[15], cw[14], cw[13], cw[12]};
	endfunction

	// One byte through the reflected CRC-16 (MODBUS polynomial), bit by bit.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
			input logic [7:0] data);
		logic [15:0] crc;
		crc = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (crc[0]) begin
				crc = (crc >> 1) ^ CRC_POLY;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

endpackage

FILE: sv/io_board_status_packet_framer.sv
`timescale 1ns / 1ps
// Status frame builder for a serial I/O board. Each poll item (control word and
// three analog readings) yields a fourteen-byte frame sent one byte per cycle
// while the output does not stall: two 0xAA sync bytes, three analog words, the
// button word, a status byte, a zero byte and a CRC-16/MODBUS, low byte first;
// frame_end marks the last byte. A poll item is taken into the input register,
// and the next one may be taken while the previous frame is still going out.
// The CRC is built one byte per cycle as the data bytes leave, pausing while
// the output stalls. Depends on iobs_pkg, iobs_format and iobs_serial.
module io_board_status_packet_framer (
	input logic clk,
	input logic arst_n,
	input logic poll_valid,
	output logic poll_stall,
	input iobs_pkg::poll_item_t poll,
	output logic frame_valid,
	input logic frame_stall,
	output iobs_pkg::frame_item_t frame
);

	logic data_valid;
	logic data_take;
	iobs_pkg::frame_data_t data;

	// Input register and data byte layout.
	iobs_format u_format (
		.clk(clk),
		.arst_n(arst_n),
		.poll_valid(poll_valid),
		.poll_stall(poll_stall),
		.poll(poll),
		.data_valid(data_valid),
		.data_take(data_take),
		.data(data)
	);

	// Byte serialiser with the running CRC.
	iobs_serial u_serial (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_take(data_take),
		.data(data),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame(frame)
	);

endmodule

FILE: sv/iobs_format.sv
`timescale 1ns / 1ps
// Input stage: registers one poll item already laid out as the ten frame data
// bytes, and tracks the coin bit for edge detection. Depends on iobs_pkg.
module iobs_format (
	input logic clk,
	input logic arst_n,
	input logic poll_valid,
	output logic poll_stall,
	input iobs_pkg::poll_item_t poll,
	output logic data_valid,
	input logic data_take,
	output iobs_pkg::frame_data_t data
);

	logic valid_s1;
	iobs_pkg::frame_data_t data_s1;
	logic coin_q;
	logic poll_take;
	logic coin_now;
	logic [15:0] a0;
	logic [15:0] a1;
	logic [15:0] a2;
	logic [15:0] btn;
	logic [7:0] status;
	iobs_pkg::frame_data_t data_next;

	// The stage takes a new item when empty or when its item moves on this cycle.
	assign poll_stall = valid_s1 && !data_take;
	assign poll_take = poll_valid && !poll_stall;

	// Lay out the data bytes of the frame, little-endian words.
	always_comb begin
		coin_now = poll.control_word[iobs_pkg::COIN_BIT];
		a0 = iobs_pkg::scale_analog(poll.steer_reading);
		a1 = iobs_pkg::scale_analog(poll.throttle_reading);
		a2 = iobs_pkg::scale_analog(poll.brake_reading);
		btn = iobs_pkg::remap_buttons(poll.control_word);
		status = iobs_pkg::STATUS_BASE;
		if (coin_now && !coin_q) begin
			status = status | iobs_pkg::STATUS_COIN;
		end
		data_next[0] = a0[7:0];
		data_next[1] = a0[15:8];
		data_next[2] = a1[7:0];
		data_next[3] = a1[15:8];
		data_next[4] = a2[7:0];
		data_next[5] = a2[15:8];
		data_next[6] = btn[7:0];
		data_next[7] = btn[15:8];
		data_next[8] = status;
		data_next[9] = 8'h00;
	end

	// Control state: stage valid and the coin bit of the last accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			coin_q <= 1'b0;
		end else begin
			if (poll_take) begin
				valid_s1 <= 1'b1;
				coin_q <= coin_now;
			end else if (data_take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		if (poll_take) begin
			data_s1 <= data_next;
		end
	end

	assign data_valid = valid_s1;
	assign data = data_s1;

endmodule

FILE: sv/iobs_serial.sv
`timescale 1ns / 1ps
// Output stage: sends one frame a byte at a time and folds each data byte into
// the running CRC as it leaves. Depends on iobs_pkg.
module iobs_serial (
	input logic clk,
	input logic arst_n,
	input logic data_valid,
	output logic data_take,
	input iobs_pkg::frame_data_t data,
	output logic frame_valid,
	input logic frame_stall,
	output iobs_pkg::frame_item_t frame
);

	logic busy_q;
	logic [iobs_pkg::IDX_W-1:0] idx_q;
	iobs_pkg::frame_data_t data_q;
	logic [15:0] crc_q;
	logic out_take;
	logic last_byte;
	logic [iobs_pkg::IDX_W-1:0] didx;
	logic [7:0] cur_byte;

	assign out_take = busy_q && !frame_stall;
	assign last_byte = (idx_q == iobs_pkg::IDX_CRC_HI);
	// A new frame loads when idle or as the last byte of the current one leaves.
	assign data_take = data_valid && (!busy_q || (out_take && last_byte));

	// Select the byte at the current frame position.
	always_comb begin
		didx = idx_q - iobs_pkg::IDX_DATA_FIRST;
		case (idx_q) inside
			[iobs_pkg::IDX_DATA_FIRST:iobs_pkg::IDX_DATA_LAST]:
				cur_byte = data_q[didx[iobs_pkg::DIDX_W-1:0]];
			iobs_pkg::IDX_CRC_LO: cur_byte = crc_q[7:0];
			iobs_pkg::IDX_CRC_HI: cur_byte = crc_q[15:8];
			default: cur_byte = iobs_pkg::SYNC_BYTE;
		endcase
	end

	// Control state: busy flag and byte position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (data_take) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (out_take) begin
				if (last_byte) begin
					busy_q <= 1'b0;
				end
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Frame data and the running CRC over the data bytes sent so far.
	always_ff @(posedge clk) begin
		if (data_take) begin
			data_q <= data;
			crc_q <= iobs_pkg::CRC_INIT;
		end else if (out_take && idx_q >= iobs_pkg::IDX_DATA_FIRST
				&& idx_q <= iobs_pkg::IDX_DATA_LAST) begin
			crc_q <= iobs_pkg::crc16_byte(crc_q, cur_byte);
		end
	end

	assign frame_valid = busy_q;
	assign frame.frame_byte = cur_byte;
	assign frame.frame_end = last_byte;

endmodule

FILE: tb/sv/io_board_status_packet_framer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for io_board_status_packet_framer: it drives poll items and
// checks every frame byte against an independent frame predictor kept in this file.
// Depends on iobs_pkg for the item types and on the framer RTL.
module io_board_status_packet_framer_tb;

	// Frame constants of the predictor.
	localparam int BYTES_PER_FRAME = 14;
	localparam int PAYLOAD_BYTES = 10;
	localparam logic [7:0] SYNC_MARK = 8'hAA;
	localparam logic [7:0] STATUS_IDLE = 8'h40;
	localparam logic [7:0] STATUS_COIN_EDGE = 8'h80;
	localparam logic [15:0] CRC_SEED = 16'hFFFF;
	localparam logic [15:0] CRC_REFLECTED_POLY = 16'hA001;
	localparam int COIN_POS = 2;
	localparam int MAX_REPORTS = 10;
	localparam int SETTLE_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic poll_valid = 1'b0;
	logic poll_stall;
	iobs_pkg::poll_item_t poll = '0;
	logic frame_valid;
	logic frame_stall = 1'b1;
	iobs_pkg::frame_item_t frame;

	// Idling rates, a long output hold request and the run statistics.
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int polls_sent = 0;
	int bytes_checked = 0;
	int mismatch_count = 0;

	// Predictor state and the frame bytes still awaited, oldest first.
	logic coin_prev = 1'b0;
	iobs_pkg::frame_item_t frame_bytes_due[$];

	io_board_status_packet_framer dut (
		.clk(clk),
		.arst_n(arst_n),
		.poll_valid(poll_valid),
		.poll_stall(poll_stall),
		.poll(poll),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame(frame)
	);

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Analog word: the inverted reading scaled by four.
	function automatic logic [15:0] analog_word(input logic [7:0] reading);
		return 16'(16'd255 - {8'd0, reading}) * 16'd4;
	endfunction

	// Button word gathered from the raw control word through a lookup of source bits.
	function automatic logic [15:0] button_word(input logic [15:0] cw);
		int src [10] = '{12, 13, 14, 15, 8, 3, 10, 9, 1, 0};
		logic [15:0] w;
		w = '0;
		for (int i = 0; i < 10; i++) begin
			w[i] = cw[src[i]];
		end
		return w;
	endfunction

	// Work out the fourteen bytes of the frame for one accepted poll item.
	task automatic predict_frame(input iobs_pkg::poll_item_t p);
		logic [7:0] payload [PAYLOAD_BYTES];
		logic [15:0] a_steer, a_throttle, a_brake, buttons, crc;
		logic [7:0] status;
		logic fb;
		iobs_pkg::frame_item_t fi;
		a_steer = analog_word(p.steer_reading);
		a_throttle = analog_word(p.throttle_reading);
		a_brake = analog_word(p.brake_reading);
		buttons = button_word(p.control_word);
		status = STATUS_IDLE;
		if (p.control_word[COIN_POS] && !coin_prev) begin
			status = status | STATUS_COIN_EDGE;
		end
		coin_prev = p.control_word[COIN_POS];
		payload[0] = a_steer[7:0];
		payload[1] = a_steer[15:8];
		payload[2] = a_throttle[7:0];
		payload[3] = a_throttle[15:8];
		payload[4] = a_brake[7:0];
		payload[5] = a_brake[15:8];
		payload[6] = buttons[7:0];
		payload[7] = buttons[15:8];
		payload[8] = status;
		payload[9] = 8'h00;
		// Serial form of the reflected CRC: one data bit at a time, LSB first.
		crc = CRC_SEED;
		for (int k = 0; k < PAYLOAD_BYTES; k++) begin
			for (int b = 0; b < 8; b++) begin
				fb = crc[0] ^ payload[k][b];
				crc = crc >> 1;
				if (fb) begin
					crc = crc ^ CRC_REFLECTED_POLY;
				end
			end
		end
		for (int k = 0; k < BYTES_PER_FRAME; k++) begin
			if (k < 2) begin
				fi.frame_byte = SYNC_MARK;
			end else if (k < 2 + PAYLOAD_BYTES) begin
				fi.frame_byte = payload[k - 2];
			end else if (k == BYTES_PER_FRAME - 2) begin
				fi.frame_byte = crc[7:0];
			end else begin
				fi.frame_byte = crc[15:8];
			end
			fi.frame_end = (k == BYTES_PER_FRAME - 1);
			frame_bytes_due.push_back(fi);
		end
	endtask

	function automatic iobs_pkg::poll_item_t poll_of(input logic [15:0] cw,
			input logic [7:0] steer, input logic [7:0] throttle, input logic [7:0] brake);
		iobs_pkg::poll_item_t p;
		p.control_word = cw;
		p.steer_reading = steer;
		p.throttle_reading = throttle;
		p.brake_reading = brake;
		return p;
	endfunction

	// Random reading, weighted towards both ends of the range.
	function automatic logic [7:0] random_reading();
		int pick;
		pick = $urandom_range(3);
		if (pick == 0) begin
			return 8'h00;
		end else if (pick == 1) begin
			return 8'hFF;
		end
		return 8'($urandom);
	endfunction

	// Random poll item; some control words only move the coin bit, to hit held and released coin.
	function automatic iobs_pkg::poll_item_t random_poll();
		logic [15:0] cw;
		int pick;
		pick = $urandom_range(9);
		if (pick < 6) begin
			cw = 16'($urandom);
		end else if (pick < 8) begin
			cw = 16'($urandom_range(1)) << COIN_POS;
		end else if (pick == 8) begin
			cw = 16'hFFFF;
		end else begin
			cw = 16'h0000;
		end
		return poll_of(cw, random_reading(), random_reading(), random_reading());
	endfunction

	// Offer one poll item, with random idle cycles first, and wait until it is accepted.
	// Valid is left high afterwards, so back-to-back items keep it high.
	task automatic send_poll(input iobs_pkg::poll_item_t p);
		while ($urandom_range(99) < sender_idle_pct) begin
			poll_valid <= 1'b0;
			poll <= random_poll();
			@(posedge clk);
		end
		poll_valid <= 1'b1;
		poll <= p;
		@(posedge clk);
		while (poll_stall) begin
			@(posedge clk);
		end
		predict_frame(p);
		polls_sent++;
	endtask

	// Lower valid in the same step as the last acceptance and wait for every frame.
	task automatic drain_frames();
		poll_valid <= 1'b0;
		while (frame_bytes_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random_polls(input int count);
		for (int i = 0; i < count; i++) begin
			send_poll(random_poll());
		end
	endtask

	// Extremes of every field, the coin edge and a held coin, and each control bit alone.
	task automatic test_directed_cases();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		send_poll(poll_of(16'h0000, 8'h00, 8'h00, 8'h00));
		send_poll(poll_of(16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
		send_poll(poll_of(16'hFFFF, 8'h80, 8'h7F, 8'h01));
		send_poll(poll_of(16'h0004, 8'h01, 8'hFE, 8'h55));
		send_poll(poll_of(16'h0000, 8'hAA, 8'h55, 8'hFF));
		send_poll(poll_of(16'h0004, 8'h00, 8'hFF, 8'h00));
		send_poll(poll_of(16'h0800, 8'hFF, 8'h00, 8'hFF));
		for (int i = 0; i < 16; i++) begin
			send_poll(poll_of(16'h0001 << i, 8'(i * 17), 8'(255 - i * 16), 8'(i)));
		end
		drain_frames();
	endtask

	task automatic test_random_slow_receiver();
		sender_idle_pct = 31;
		receiver_stall_pct = 74;
		run_random_polls(70);
		drain_frames();
	endtask

	task automatic test_random_slow_sender();
		sender_idle_pct = 74;
		receiver_stall_pct = 31;
		run_random_polls(70);
		drain_frames();
	endtask

	task automatic test_random_full_rate();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		run_random_polls(60);
		drain_frames();
	endtask

	// The receiver holds off for a long stretch while items keep coming, so the block fills.
	task automatic test_output_backpressure();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		@(negedge clk);
		hold_request = 250;
		@(posedge clk);
		run_random_polls(12);
		drain_frames();
	endtask

	// Output stall: a long hold when one is requested, random stalls otherwise.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			frame_stall <= 1'b1;
		end else begin
			frame_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	// Compare each accepted frame byte with the oldest one awaited.
	always @(posedge clk) begin
		iobs_pkg::frame_item_t want;
		if (arst_n && frame_valid && !frame_stall) begin
			bytes_checked++;
			if (frame_bytes_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("%0t: frame byte %02h end %0b arrived with none awaited",
						$realtime, frame.frame_byte, frame.frame_end);
				end
			end else begin
				want = frame_bytes_due.pop_front();
				if (frame.frame_byte !== want.frame_byte) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("%0t: frame_byte expected %02h, got %02h",
							$realtime, want.frame_byte, frame.frame_byte);
					end
				end
				if (frame.frame_end !== want.frame_end) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("%0t: frame_end expected %0b, got %0b",
							$realtime, want.frame_end, frame.frame_end);
					end
				end
			end
		end
	end

	// Main sequence: reset once, run every test, then report.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_slow_receiver();
		test_random_slow_sender();
		test_random_full_rate();
		test_output_backpressure();
		$display("Sent %0d poll items and checked %0d frame bytes over directed cases,",
			polls_sent, bytes_checked);
		$display("three idling mixes and a long output hold-off; %0d mismatches.",
			mismatch_count);
		if (mismatch_count == 0 && frame_bytes_due.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Guard against a hang.
	initial begin
		#400000;
		$display("Timeout with %0d frame bytes still awaited", frame_bytes_due.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
